// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the spring force unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SFU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SFU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sfu_pkg.sv =====
// Types, constants and codes of the spring force unit.
package sfu_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 32;
    localparam int SQ_W        = 2 * POS_W;
    localparam int RAD_W       = SQ_W + 2;
    localparam int LEN_W       = RAD_W / 2;
    localparam int SQ_STEPS    = LEN_W;
    localparam int SQ_REM_W    = LEN_W + 3;
    localparam int REST_W      = 31;
    localparam int K_W         = 32;
    localparam int DISP_W      = LEN_W + 1;
    localparam int ADISP_W     = LEN_W;
    localparam int HI_W        = ADISP_W - FRAC_BITS;
    localparam int M_W         = K_W + ADISP_W - FRAC_BITS;
    localparam int MH_W        = 33;
    localparam int U_W         = FRAC_BITS + 1;
    localparam int DIV_STEPS   = U_W;
    localparam int DR_W        = LEN_W + 1;
    localparam int MAG_W       = MH_W + U_W + 1;
    localparam int OV_W        = 2 * MH_W + FRAC_BITS;
    localparam logic [OV_W-1:0] OVER_LIM = OV_W'(64'h1_0000_0001) << FRAC_BITS;
    localparam int CFG_IDX_W   = 3;
    localparam int LANES       = 3;

    localparam logic [1:0] MODE_PAIR   = 2'd0;
    localparam logic [1:0] MODE_ANCHOR = 2'd1;
    localparam logic [1:0] MODE_BUNGEE = 2'd2;

    localparam logic [1:0] OUT_APPLIED  = 2'd0;
    localparam logic [1:0] OUT_SLACK    = 2'd1;
    localparam logic [1:0] OUT_ZERO_LEN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONSTANT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z = 3'd5;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
        logic signed [POS_W-1:0] other_z;
    } sfu_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] force_x;
        logic signed [POS_W-1:0] force_y;
        logic signed [POS_W-1:0] force_z;
        logic [1:0]              outcome;
        logic                    saturated;
    } sfu_res_t;

    // Per-axis magnitude and sign of the spring vector.
    typedef struct packed {
        logic [LANES-1:0][POS_W-1:0] ad;
        logic [LANES-1:0]            dneg;
    } sfu_vec_t;

    // Scalar force terms carried alongside the divider.
    typedef struct packed {
        logic [MH_W-1:0]      mh;
        logic [FRAC_BITS-1:0] ml;
        logic                 over;
        logic                 dpos;
        logic [LANES-1:0]     dneg;
        logic [1:0]           outcome;
    } sfu_post_t;

endpackage

// ===== hdl/sfu_sqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
`include "assert_macros.svh"

module sfu_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [sfu_pkg::RAD_W-1:0]    rad,
    input  sfu_pkg::sfu_vec_t            side_in,
    output logic                         out_valid,
    output logic [sfu_pkg::LEN_W-1:0]    root,
    output sfu_pkg::sfu_vec_t            side_out
);
    import sfu_pkg::*;

    logic                  vld_reg  [SQ_STEPS];
    logic [RAD_W-1:0]      rad_reg  [SQ_STEPS];
    logic [LEN_W-1:0]      root_reg [SQ_STEPS];
    logic [SQ_REM_W-1:0]   rem_reg  [SQ_STEPS];
    sfu_vec_t              side_reg [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_stage
        logic                p_vld;
        logic [RAD_W-1:0]    p_rad;
        logic [LEN_W-1:0]    p_root;
        logic [SQ_REM_W-1:0] p_rem;
        sfu_vec_t            p_side;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [LEN_W-1:0]    root_next;
        logic                ge;

        if (s == 0) begin : g_first
            assign p_vld  = in_valid;
            assign p_rad  = rad;
            assign p_root = '0;
            assign p_rem  = '0;
            assign p_side = side_in;
        end else begin : g_next
            assign p_vld  = vld_reg[s-1];
            assign p_rad  = rad_reg[s-1];
            assign p_root = root_reg[s-1];
            assign p_rem  = rem_reg[s-1];
            assign p_side = side_reg[s-1];
        end

        // bring down the next bit pair, most significant first
        assign rem_sh    = {p_rem[SQ_REM_W-3:0], p_rad[2*(SQ_STEPS-1-s)+1 -: 2]};
        assign trial     = SQ_REM_W'({p_root, 2'b01});
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {p_root[LEN_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[s] <= 1'b0;
            end else begin
                vld_reg[s] <= p_vld;
            end
        end

        always_ff @(posedge clk) begin
            rad_reg[s]  <= p_rad;
            root_reg[s] <= root_next;
            rem_reg[s]  <= rem_next;
            side_reg[s] <= p_side;
        end
    end

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign root      = root_reg[SQ_STEPS-1];
    assign side_out  = side_reg[SQ_STEPS-1];

    // remainder of a floor root never exceeds twice the root
    `SFU_ASSERT_IMP(a_sq_rem_bound, vld_reg[SQ_STEPS-1],
        rem_reg[SQ_STEPS-1] <= SQ_REM_W'({root_reg[SQ_STEPS-1], 1'b0}),
        "sqrt remainder out of bound")

endmodule

// ===== hdl/sfu_div.sv =====
// Pipelined three-lane restoring divider for the unit vector, one bit per stage.
module sfu_div (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  logic [sfu_pkg::LEN_W-1:0]                      len,
    input  logic [sfu_pkg::LANES-1:0][sfu_pkg::POS_W-1:0]  ad,
    input  sfu_pkg::sfu_post_t                             post_in,
    output logic                                           out_valid,
    output logic [sfu_pkg::LANES-1:0][sfu_pkg::U_W-1:0]    quot,
    output sfu_pkg::sfu_post_t                             post_out
);
    import sfu_pkg::*;

    logic                          vld_reg  [DIV_STEPS];
    logic [LEN_W-1:0]              len_reg  [DIV_STEPS];
    logic [LANES-1:0][DR_W-1:0]    r_reg    [DIV_STEPS];
    logic [LANES-1:0][U_W-1:0]     q_reg    [DIV_STEPS];
    sfu_post_t                     post_reg [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
        logic                       p_vld;
        logic [LEN_W-1:0]           p_len;
        logic [LANES-1:0][DR_W-1:0] p_r;
        logic [LANES-1:0][U_W-1:0]  p_q;
        logic [LANES-1:0]           p_bit;
        sfu_post_t                  p_post;
        logic [LANES-1:0][DR_W-1:0] r_next;
        logic [LANES-1:0][U_W-1:0]  q_next;

        if (s == 0) begin : g_first
            // dividend is ad << FRAC_BITS; quotient fits FRAC_BITS+1 bits
            assign p_vld  = in_valid;
            assign p_len  = len;
            assign p_q    = '0;
            assign p_post = post_in;
            for (genvar l = 0; l < LANES; l++) begin : g_init
                assign p_r[l]   = DR_W'(ad[l] >> 1);
                assign p_bit[l] = ad[l][0];
            end
        end else begin : g_next
            assign p_vld  = vld_reg[s-1];
            assign p_len  = len_reg[s-1];
            assign p_r    = r_reg[s-1];
            assign p_q    = q_reg[s-1];
            assign p_bit  = '0;
            assign p_post = post_reg[s-1];
        end

        always_comb begin
            logic [DR_W-1:0] rsh;
            logic            ge;
            for (int l = 0; l < LANES; l++) begin
                rsh       = {p_r[l][DR_W-2:0], p_bit[l]};
                ge        = (rsh >= DR_W'(p_len));
                r_next[l] = ge ? (rsh - DR_W'(p_len)) : rsh;
                q_next[l] = {p_q[l][U_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[s] <= 1'b0;
            end else begin
                vld_reg[s] <= p_vld;
            end
        end

        always_ff @(posedge clk) begin
            len_reg[s]  <= p_len;
            r_reg[s]    <= r_next;
            q_reg[s]    <= q_next;
            post_reg[s] <= p_post;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quot      = q_reg[DIV_STEPS-1];
    assign post_out  = post_reg[DIV_STEPS-1];

endmodule

// ===== hdl/spring_force_unit_core.sv =====
// Top level of the spring force unit: config registers, front end, force pipeline.
//
// Usage
//   Request channel: drive request and pulse start; a request is taken at
//   each rising edge with start high and busy low. busy is held low, so one
//   request may be taken every cycle, back to back.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver must take it then. Results leave in request order.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 mode, 1 stiffness,
//   2 rest length, 3..5 anchor x/y/z) and cfg_data. cfg_ready is always
//   high. Write only while no request is in flight; other indexes are dropped.
// Timing
//   Throughput is one request per cycle; the 33-stage square root and the
//   17-stage divider set the depth, one result bit per stage.
// Reset
//   rst_n clears all valid bits (nothing in flight) and loads mode 0,
//   stiffness 1.0, rest length 1.0 and the anchor at the origin.
`include "assert_macros.svh"

module spring_force_unit_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sfu_pkg::sfu_req_t                   request,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data,
    output logic                                done,
    output sfu_pkg::sfu_res_t                   result
);
    import sfu_pkg::*;

    // ---------------- configuration registers ----------------
    logic [1:0]               mode_reg;
    logic [K_W-1:0]           k_reg;
    logic [REST_W-1:0]        rest_reg;
    logic signed [POS_W-1:0]  anchor_x_reg;
    logic signed [POS_W-1:0]  anchor_y_reg;
    logic signed [POS_W-1:0]  anchor_z_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg     <= MODE_PAIR;
            k_reg        <= K_W'(32'h0001_0000);
            rest_reg     <= REST_W'(32'h0001_0000);
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            anchor_z_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[1:0];
                REG_CONSTANT: k_reg        <= cfg_data;
                REG_REST:     rest_reg     <= cfg_data[REST_W-1:0];
                REG_ANCHOR_X: anchor_x_reg <= cfg_data;
                REG_ANCHOR_Y: anchor_y_reg <= cfg_data;
                REG_ANCHOR_Z: anchor_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage A: spring vector d = p - q ----------------
    logic                                take;
    logic signed [POS_W-1:0]             q_sel [LANES];
    logic signed [POS_W-1:0]             p_sel [LANES];
    sfu_vec_t                            vec_next;
    logic                                a_vld_reg;
    sfu_vec_t                            a_vec_reg;

    assign take = start && !busy;

    always_comb begin
        logic signed [POS_W:0] diff;
        p_sel[0] = request.pos_x;
        p_sel[1] = request.pos_y;
        p_sel[2] = request.pos_z;
        if (mode_reg == MODE_ANCHOR) begin
            q_sel[0] = anchor_x_reg;
            q_sel[1] = anchor_y_reg;
            q_sel[2] = anchor_z_reg;
        end else begin
            q_sel[0] = request.other_x;
            q_sel[1] = request.other_y;
            q_sel[2] = request.other_z;
        end
        for (int i = 0; i < LANES; i++) begin
            diff = {p_sel[i][POS_W-1], p_sel[i]} - {q_sel[i][POS_W-1], q_sel[i]};
            vec_next.dneg[i] = diff[POS_W];
            vec_next.ad[i]   = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
        end
    end

    // ---------------- stage B: squares ----------------
    logic                          b_vld_reg;
    sfu_vec_t                      b_vec_reg;
    logic [LANES-1:0][SQ_W-1:0]    b_sq_reg;

    // ---------------- stage C: sum of squares ----------------
    logic                          c_vld_reg;
    sfu_vec_t                      c_vec_reg;
    logic [RAD_W-1:0]              c_rad_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= take;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        a_vec_reg <= vec_next;
        b_vec_reg <= a_vec_reg;
        for (int i = 0; i < LANES; i++) begin
            b_sq_reg[i] <= SQ_W'(a_vec_reg.ad[i] * a_vec_reg.ad[i]);
        end
        c_vec_reg <= b_vec_reg;
        c_rad_reg <= RAD_W'(b_sq_reg[0]) + RAD_W'(b_sq_reg[1]) + RAD_W'(b_sq_reg[2]);
    end

    // ---------------- length: floor square root ----------------
    logic              s_vld;
    logic [LEN_W-1:0]  s_len;
    sfu_vec_t          s_vec;

    sfu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_vld_reg),
        .rad       (c_rad_reg),
        .side_in   (c_vec_reg),
        .out_valid (s_vld),
        .root      (s_len),
        .side_out  (s_vec)
    );

    // ---------------- stage D: stretch and outcome ----------------
    logic signed [DISP_W-1:0]  disp;
    logic [ADISP_W-1:0]        adisp_next;
    logic [1:0]                outcome_next;

    logic                      d_vld_reg;
    logic [LEN_W-1:0]          d_len_reg;
    logic [ADISP_W-1:0]        d_adisp_reg;
    logic                      d_dpos_reg;
    logic [1:0]                d_outcome_reg;
    sfu_vec_t                  d_vec_reg;

    always_comb begin
        disp       = $signed({1'b0, s_len}) - $signed(DISP_W'(rest_reg));
        adisp_next = disp[DISP_W-1] ? ADISP_W'(-disp) : disp[ADISP_W-1:0];
        // zero length wins over the slack bungee test; mode 3 acts as bungee
        if (s_len == '0) begin
            outcome_next = OUT_ZERO_LEN;
        end else if (mode_reg[1] && (s_len <= LEN_W'(rest_reg))) begin
            outcome_next = OUT_SLACK;
        end else begin
            outcome_next = OUT_APPLIED;
        end
    end

    // ---------------- stage E: k * |stretch| partial products ----------------
    logic                          e_vld_reg;
    logic [LEN_W-1:0]              e_len_reg;
    logic [K_W+HI_W-1:0]           e_phi_reg;
    logic [K_W+FRAC_BITS-1:0]      e_plo_reg;
    logic                          e_dpos_reg;
    logic [1:0]                    e_outcome_reg;
    sfu_vec_t                      e_vec_reg;

    // ---------------- stage F: m = floor(k * |stretch| / 2^F) ----------------
    logic                          f_vld_reg;
    logic [LEN_W-1:0]              f_len_reg;
    sfu_vec_t                      f_vec_reg;
    sfu_post_t                     f_post_reg;
    logic [M_W-1:0]                m_sum;
    sfu_post_t                     post_next;

    always_comb begin
        m_sum = M_W'(e_phi_reg) + M_W'(e_plo_reg >> FRAC_BITS);
        post_next.mh      = MH_W'(m_sum >> FRAC_BITS);
        post_next.ml      = m_sum[FRAC_BITS-1:0];
        post_next.over    = (OV_W'(m_sum) >= OVER_LIM);
        post_next.dpos    = e_dpos_reg;
        post_next.dneg    = e_vec_reg.dneg;
        post_next.outcome = e_outcome_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end else begin
            d_vld_reg <= s_vld;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        d_len_reg     <= s_len;
        d_adisp_reg   <= adisp_next;
        d_dpos_reg    <= !disp[DISP_W-1] && (disp != '0);
        d_outcome_reg <= outcome_next;
        d_vec_reg     <= s_vec;

        e_len_reg     <= d_len_reg;
        e_phi_reg     <= (K_W+HI_W)'(k_reg * d_adisp_reg[ADISP_W-1:FRAC_BITS]);
        e_plo_reg     <= (K_W+FRAC_BITS)'(k_reg * d_adisp_reg[FRAC_BITS-1:0]);
        e_dpos_reg    <= d_dpos_reg;
        e_outcome_reg <= d_outcome_reg;
        e_vec_reg     <= d_vec_reg;

        f_len_reg     <= e_len_reg;
        f_vec_reg     <= e_vec_reg;
        f_post_reg    <= post_next;
    end

    // ---------------- unit vector: |d_i| * 2^F / len ----------------
    logic                              v_vld;
    logic [LANES-1:0][U_W-1:0]         v_u;
    sfu_post_t                         v_post;

    sfu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld_reg),
        .len       (f_len_reg),
        .ad        (f_vec_reg.ad),
        .post_in   (f_post_reg),
        .out_valid (v_vld),
        .quot      (v_u),
        .post_out  (v_post)
    );

    // ---------------- stage G: m * u partial products ----------------
    logic                                  g_vld_reg;
    logic [LANES-1:0][MH_W+U_W-1:0]        g_ph_reg;
    logic [LANES-1:0][FRAC_BITS+U_W-1:0]   g_pl_reg;
    logic [LANES-1:0]                      g_over_reg;
    sfu_post_t                             g_post_reg;

    // ---------------- stage H: sign, clamp, result ----------------
    logic       done_reg;
    sfu_res_t   res_reg;
    sfu_res_t   res_next;

    always_comb begin
        logic [MAG_W-1:0]      mag;
        logic                  neg;
        logic                  sat_any;
        logic [POS_W-1:0]      comp [LANES];
        sat_any = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            mag = MAG_W'(g_ph_reg[i]) + MAG_W'(g_pl_reg[i] >> FRAC_BITS);
            neg = (g_post_reg.dpos != g_post_reg.dneg[i]);
            if (neg) begin
                if (g_over_reg[i] || (mag > MAG_W'(33'h0_8000_0000))) begin
                    sat_any = 1'b1;
                    mag     = MAG_W'(33'h0_8000_0000);
                end
                comp[i] = POS_W'(-mag);
            end else begin
                if (g_over_reg[i] || (mag > MAG_W'(33'h0_7FFF_FFFF))) begin
                    sat_any = 1'b1;
                    mag     = MAG_W'(33'h0_7FFF_FFFF);
                end
                comp[i] = mag[POS_W-1:0];
            end
        end
        res_next.outcome = g_post_reg.outcome;
        if (g_post_reg.outcome == OUT_APPLIED) begin
            res_next.force_x   = comp[0];
            res_next.force_y   = comp[1];
            res_next.force_z   = comp[2];
            res_next.saturated = sat_any;
        end else begin
            res_next.force_x   = '0;
            res_next.force_y   = '0;
            res_next.force_z   = '0;
            res_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            g_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            g_vld_reg <= v_vld;
            done_reg  <= g_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < LANES; i++) begin
            g_ph_reg[i]   <= (MH_W+U_W)'(v_post.mh * v_u[i]);
            g_pl_reg[i]   <= (FRAC_BITS+U_W)'(v_post.ml * v_u[i]);
            // a zero unit component gives zero force even for a huge m
            g_over_reg[i] <= v_post.over && (v_u[i] != '0);
        end
        g_post_reg <= v_post;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // ---------------- checks ----------------
    `SFU_ASSERT_IMP(a_idle_force_zero, done && (result.outcome != OUT_APPLIED),
        (result.force_x == '0) && (result.force_y == '0) && (result.force_z == '0),
        "zero-force outcome with nonzero force")
    `SFU_ASSERT_IMP(a_sat_only_applied, done && result.saturated,
        result.outcome == OUT_APPLIED,
        "saturation flagged without applied force")
    `SFU_ASSERT_IMP(a_slack_only_bungee, done && (result.outcome == OUT_SLACK),
        mode_reg[1],
        "slack outcome outside bungee mode")
    `SFU_ASSERT_NXT(a_mode_write, cfg_valid && cfg_ready && (cfg_index == REG_MODE),
        mode_reg == $past(cfg_data[1:0]),
        "mode register write lost")

endmodule
